// ===== design/ra_pkg.sv =====
// shared constants and types for the rank assigner
package ra_pkg;

   localparam int MAX_ITEMS   = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int RANK_W      = 7;
   localparam int CNT_W       = $clog2(MAX_ITEMS + 1);

   typedef logic [VALUE_WIDTH-1:0] key_type;
   typedef logic [RANK_W-1:0]      rank_type;
   typedef logic [CNT_W-1:0]       count_type;

   typedef struct packed {
      logic     valid;
      key_type  key;
      rank_type smaller;
   } token_type;

   typedef struct packed {
      logic     valid;
      rank_type rank;
   } slot_type;

   function automatic key_type order_key(input logic [VALUE_WIDTH-1:0] raw);
      key_type k;
      k = raw;
      k[VALUE_WIDTH-1] = ~raw[VALUE_WIDTH-1];
      return k;
   endfunction

endpackage

// ===== design/ra_if.sv =====
// request and response channel interfaces
interface ra_req_if;
   import ra_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_WIDTH-1:0] value;
   logic                         last_in;
   modport source (output valid, value, last_in, input ready);
   modport sink   (input valid, value, last_in, output ready);
endinterface

interface ra_rsp_if;
   import ra_pkg::*;
   logic              valid;
   logic              ready;
   logic [RANK_W-1:0] rank;
   logic              overflowed;
   logic              last_out;
   modport source (output valid, rank, overflowed, last_out, input ready);
   modport sink   (input valid, rank, overflowed, last_out, output ready);
endinterface

// ===== design/rank_assigner_top.sv =====
// top level of the rank assigner: input stage, cell chain and result drain
//
// req_ch carries one signed value per transfer plus last_in. Values enter a
// chain of MAX_ITEMS cells; each travels one cell per cycle, counting stored
// values smaller than itself and bumping the rank of stored values larger
// than itself, and settles in the first empty cell. Values are accepted one
// per cycle until the transfer carrying last_in.
// After last_in, req_ch.ready stays low until the final result of the set
// has moved into the output register. The chain first empties of values in
// flight, then ranks shift out of the chain in load order on rsp_ch, one per
// cycle while rsp_ch accepts them, the final one with last_out set. Values
// beyond MAX_ITEMS are dropped and overflowed is set on every result of that
// set. A stalled rsp_ch holds the current result in the output register and
// freezes the drain. Synchronous reset empties the chain and clears the
// overflow flag, the fill count and the output valid.
module rank_assigner_top (
   input  logic     clock,
   input  logic     reset,
   ra_req_if.sink   req_ch,
   ra_rsp_if.source rsp_ch
);
   import ra_pkg::*;

   token_type inj_ff, inj_in;
   count_type count_ff, count_in;
   logic      ovf_ff, ovf_in;
   logic      flush_ff, flush_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rank_type  rsp_rank_ff, rsp_rank_in;
   logic      rsp_ovf_ff, rsp_ovf_in;
   logic      rsp_last_ff, rsp_last_in;

   token_type             tok [MAX_ITEMS+1];
   slot_type              slots [MAX_ITEMS+1];
   logic [MAX_ITEMS-1:0]  tok_busy;
   logic                  busy, shift, last_slot, accept;

   assign tok[0]            = inj_ff;
   assign slots[MAX_ITEMS]  = '0;

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      ra_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .tok_in     (tok[i]),
         .tok_out    (tok[i+1]),
         .shift      (shift),
         .right_slot (slots[i+1]),
         .slot       (slots[i])
      );
      assign tok_busy[i] = tok[i+1].valid;
   end

   assign busy      = inj_ff.valid | (|tok_busy);
   assign shift     = flush_ff && !busy && slots[0].valid && (!rsp_valid_ff || rsp_ch.ready);
   assign last_slot = !slots[1].valid;
   assign accept    = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !flush_ff;

   always_comb begin
      inj_in       = inj_ff;
      inj_in.valid = 1'b0;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      flush_in     = flush_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_rank_in  = rsp_rank_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      if (accept) begin
         if (count_ff == count_type'(MAX_ITEMS)) begin
            ovf_in = 1'b1;
         end else begin
            inj_in.valid   = 1'b1;
            inj_in.key     = order_key(req_ch.value);
            inj_in.smaller = '0;
            count_in       = count_ff + count_type'(1);
         end
         if (req_ch.last_in) begin
            flush_in = 1'b1;
         end
      end
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (shift) begin
         rsp_valid_in = 1'b1;
         rsp_rank_in  = slots[0].rank;
         rsp_ovf_in   = ovf_ff;
         rsp_last_in  = last_slot;
         if (last_slot) begin
            count_in = '0;
            ovf_in   = 1'b0;
            flush_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inj_ff.valid <= 1'b0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         inj_ff.valid <= inj_in.valid;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      inj_ff.key     <= inj_in.key;
      inj_ff.smaller <= inj_in.smaller;
      rsp_rank_ff    <= rsp_rank_in;
      rsp_ovf_ff     <= rsp_ovf_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.rank       = rsp_rank_ff;
   assign rsp_ch.overflowed = rsp_ovf_ff;
   assign rsp_ch.last_out   = rsp_last_ff;

endmodule

// ===== design/ra_cell.sv =====
// one storage cell of the ranking chain
module ra_cell (
   input  logic              clock,
   input  logic              reset,
   input  ra_pkg::token_type tok_in,
   output ra_pkg::token_type tok_out,
   input  logic              shift,
   input  ra_pkg::slot_type  right_slot,
   output ra_pkg::slot_type  slot
);
   import ra_pkg::*;

   logic      valid_ff, valid_in;
   rank_type  rank_ff, rank_in;
   key_type   key_ff, key_in;
   token_type tok_ff, tok_in_nx;

   always_comb begin
      valid_in  = valid_ff;
      rank_in   = rank_ff;
      key_in    = key_ff;
      tok_in_nx = tok_in;
      tok_in_nx.valid = 1'b0;
      if (shift) begin
         valid_in = right_slot.valid;
         rank_in  = right_slot.rank;
      end else if (tok_in.valid) begin
         if (!valid_ff) begin
            valid_in = 1'b1;
            key_in   = tok_in.key;
            rank_in  = tok_in.smaller + rank_type'(1);
         end else begin
            if (key_ff > tok_in.key) begin
               rank_in = rank_ff + rank_type'(1);
            end
            tok_in_nx.valid = 1'b1;
            if (key_ff < tok_in.key) begin
               tok_in_nx.smaller = tok_in.smaller + rank_type'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         tok_ff.valid <= tok_in_nx.valid;
      end
      rank_ff        <= rank_in;
      key_ff         <= key_in;
      tok_ff.key     <= tok_in_nx.key;
      tok_ff.smaller <= tok_in_nx.smaller;
   end

   assign tok_out    = tok_ff;
   assign slot.valid = valid_ff;
   assign slot.rank  = rank_ff;

endmodule

// ===== dv/rank_assigner_top_tb.sv =====
// testbench for rank_assigner_top: random value sets checked against a predicted rank list
`timescale 1ns / 1ps

module rank_assigner_top_tb;
   import ra_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 200;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          last;
   } load_item_type;

   typedef struct {
      rank_type rank;
      logic     overflowed;
      logic     last_out;
   } rank_result_type;

   logic clock;
   logic reset;
   logic hold_off;

   ra_req_if req_ch();
   ra_rsp_if rsp_ch();

   rank_assigner_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   load_item_type   pending[$];
   rank_result_type rank_q[$];

   logic signed [VALUE_WIDTH-1:0] held_vals[MAX_ITEMS];
   rank_type                      held_ranks[MAX_ITEMS];
   int                            held_count = 0;
   logic                          truncated = 1'b0;

   load_item_type   offered;
   rank_result_type want;
   int planned;
   int accepted = 0;
   int received = 0;
   int mismatches = 0;
   int cycles = 0;
   int send_gap;
   int send_calm = 0;
   int take_gap;
   int take_calm = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // signed compare of the new value against every held value while the set has room
   task automatic load_value(input load_item_type it);
      int lesser;
      lesser = 0;
      if (held_count < MAX_ITEMS) begin
         for (int i = 0; i < held_count; i++) begin
            if (held_vals[i] > it.value) held_ranks[i] = held_ranks[i] + 1'b1;
            else if (held_vals[i] < it.value) lesser++;
         end
         held_vals[held_count]  = it.value;
         held_ranks[held_count] = rank_type'(lesser + 1);
         held_count++;
      end else begin
         truncated = 1'b1;
      end
      if (it.last) begin
         for (int i = 0; i < held_count; i++)
            rank_q.push_back('{rank: held_ranks[i], overflowed: truncated,
                               last_out: (i == held_count - 1)});
         held_count = 0;
         truncated  = 1'b0;
      end
   endtask

   task automatic queue_value(input logic signed [VALUE_WIDTH-1:0] v, input logic last);
      load_item_type it;
      it.value = v;
      it.last  = last;
      pending.push_back(it);
      planned++;
   endtask

   task automatic queue_set(input int n);
      logic signed [VALUE_WIDTH-1:0] v;
      int tie_pct;
      tie_pct = $urandom_range(0, 2) * 40;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < tie_pct) v = $signed($urandom_range(0, 6)) - 3;
         else v = $urandom;
         queue_value(v, i == n - 1);
      end
   endtask

   task automatic flag_result(input string msg);
      if (mismatches < 10) $display("%s", msg);
      mismatches++;
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.value   <= '0;
         req_ch.last_in <= 1'b0;
         send_gap = 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            load_value(offered);
            accepted++;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending.size() != 0) begin
            offered = pending.pop_front();
            req_ch.valid   <= 1'b1;
            req_ch.value   <= offered.value;
            req_ch.last_in <= offered.last;
            if (send_calm > 0) begin
               send_calm--;
            end else begin
               send_gap = idle_len();
               if ($urandom_range(0, 9) == 0) send_calm = $urandom_range(16, 40);
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver and result check
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (rank_q.size() == 0) begin
               flag_result($sformatf("unexpected result %0d: rank %0d ovf %b last %b",
                  received, rsp_ch.rank, rsp_ch.overflowed, rsp_ch.last_out));
            end else begin
               want = rank_q.pop_front();
               if (rsp_ch.rank !== want.rank || rsp_ch.overflowed !== want.overflowed ||
                   rsp_ch.last_out !== want.last_out)
                  flag_result($sformatf({"result %0d mismatch: expected rank %0d ovf %b ",
                     "last %b, got rank %0d ovf %b last %b"}, received, want.rank,
                     want.overflowed, want.last_out, rsp_ch.rank, rsp_ch.overflowed,
                     rsp_ch.last_out));
            end
            received++;
         end
         if (hold_off) begin
            rsp_ch.ready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (take_calm > 0) begin
               take_calm--;
            end else begin
               take_gap = idle_len();
               if ($urandom_range(0, 9) == 0) take_calm = $urandom_range(16, 40);
            end
         end
      end
   end

   // long receiver stall while a full set is waiting to drain
   initial begin
      hold_off = 1'b0;
      while (rank_q.size() < 32) @(posedge clock);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      planned = 0;

      // single value
      queue_value(0, 1'b1);
      // extremes
      queue_value(32'sh7fffffff, 1'b0);
      queue_value(32'sh80000000, 1'b0);
      queue_value(0, 1'b0);
      queue_value(-1, 1'b0);
      queue_value(1, 1'b1);
      // shared ranks
      queue_value(5, 1'b0);
      queue_value(5, 1'b0);
      queue_value(-3, 1'b0);
      queue_value(5, 1'b0);
      queue_value(-3, 1'b1);
      // all equal
      for (int i = 0; i < 4; i++) queue_value(32'sh80000000, i == 3);
      // descending then ascending
      for (int i = 3; i >= 0; i--) queue_value(i, i == 0);
      for (int i = 0; i < 3; i++) queue_value(i - 1, i == 2);

      while (planned < 30) queue_set($urandom_range(1, 8));
      queue_set(MAX_ITEMS);
      while (planned < 100) queue_set($urandom_range(1, 12));
      // last transfer lands past capacity and is dropped
      queue_set(MAX_ITEMS + $urandom_range(1, 4));
      while (planned < 172) queue_set($urandom_range(1, 4));

      while (accepted < planned) @(posedge clock);
      while (rank_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
design/ra_pkg.sv
design/ra_if.sv
design/ra_cell.sv
design/rank_assigner_top.sv
dv/rank_assigner_top_tb.sv
